// File: rtl/core/dsct_pkg.sv
// Package with the shared types and constants of the duration statistics table.
package dsct_pkg;

  // Number of table entries and the address width that follows from it.
  localparam int POINTS = 256;
  localparam int IDX_W  = (POINTS > 1) ? $clog2(POINTS) : 1;

  // Depth of the queue between the front and the back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  // Codes of the kind field.
  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // Input word.
  typedef struct packed {
    logic        kind;
    logic [9:0]  point_index;
    logic [31:0] tick_count;
    logic [15:0] weight;
  } request_t;

  // Result word, also the layout of one table entry.
  typedef struct packed {
    logic [63:0] call_count;
    logic [63:0] tick_total;
    logic [31:0] tick_max;
    logic        estimated;
  } result_t;

  // Classified operation as it waits in the queue.
  typedef struct packed {
    logic             rd;
    logic             in_table;
    logic [IDX_W-1:0] addr;
    logic [31:0]      tick_count;
    logic [15:0]      weight;
  } op_t;

  // Head of the queue as the back sees it.
  typedef struct packed {
    logic valid;
    op_t  op;
  } queue_head_t;

  // States of the back sequencer.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_UPDATE
  } back_state_t;

endpackage

// File: rtl/core/dsct_front.sv
// Front: accepts words, drops records past the table and queues the rest.
module dsct_front
  import dsct_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  request_t    request,
  output logic        busy,
  output queue_head_t head,
  input  logic        pop
);

  op_t               slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              accept;
  logic              in_table;
  logic              push;
  op_t               op_in;

  // Classify the incoming word.
  always_comb begin
    accept   = start & ~busy;
    in_table = {1'b0, request.point_index} < 11'(POINTS);
    push     = accept & ((request.kind == KIND_READ) | in_table);
    op_in.rd         = (request.kind == KIND_READ);
    op_in.in_table   = in_table;
    op_in.addr       = request.point_index[IDX_W-1:0];
    op_in.tick_count = request.tick_count;
    op_in.weight     = request.weight;
  end

  assign busy = (count == (QPTR_W + 1)'(QDEPTH));

  assign head.valid = (count != '0);
  assign head.op    = slots[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= op_in;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/core/dsct_back.sv
// Back: read-modify-write of one table entry per operation.
module dsct_back
  import dsct_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  queue_head_t head,
  output logic        pop,
  output logic        done,
  output result_t     result
);

  result_t          mem [POINTS];
  logic [POINTS-1:0] valid_bits;
  back_state_t      state;
  back_state_t      state_next;
  op_t              op;
  result_t          rd_entry;
  logic             rd_valid;
  logic [47:0]      product;
  result_t          cur;
  result_t          upd;
  logic             wr_en;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and queue pop.
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    case (state)
      BK_IDLE: begin
        if (head.valid) begin
          pop        = 1'b1;
          state_next = BK_FETCH;
        end
      end
      BK_FETCH: begin
        state_next = BK_UPDATE;
      end
      BK_UPDATE: begin
        if (head.valid) begin
          pop        = 1'b1;
          state_next = BK_FETCH;
        end else begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // Operation register, loaded as the queue head is taken.
  always_ff @(posedge clk) begin
    if (pop) begin
      op <= head.op;
    end
  end

  // Entry read and weighted tick product.
  always_ff @(posedge clk) begin
    if (state == BK_FETCH) begin
      rd_entry <= mem[op.addr];
      rd_valid <= valid_bits[op.addr];
      product  <= 48'(op.tick_count) * 48'(op.weight);
    end
  end

  // New entry value; an entry never written since its last clear reads as zero.
  always_comb begin
    cur = rd_valid ? rd_entry : '0;
    upd.call_count = cur.call_count + 64'(op.weight);
    upd.tick_total = cur.tick_total + 64'(product);
    upd.tick_max   = (op.tick_count > cur.tick_max) ? op.tick_count : cur.tick_max;
    upd.estimated  = cur.estimated | (op.weight > 16'd1);
    wr_en = (state == BK_UPDATE) & ~op.rd;
  end

  // Table storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[op.addr] <= upd;
    end
  end

  // Valid bits: set by a record, cleared by a read.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (state == BK_UPDATE && op.in_table) begin
      valid_bits[op.addr] <= ~op.rd;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == BK_UPDATE) & op.rd;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_UPDATE && op.rd) begin
      result <= op.in_table ? cur : '0;
    end
  end

endmodule

// File: rtl/core/duration_stats_counter_table.sv
// Top level of the duration statistics table.
//
//   Channel   Direction  Handshake                Payload
//   request   in         start high, busy low     request_t
//   result    out        done strobe, one cycle   result_t
//
// Each operation passes through the fetch and update states of the back, set
// by the read-modify-write of one entry through the registered memory read.
// A read word passes the queue and the operation, entry read and result registers.
// Reset clears a valid bit per entry at once, so there is no clearing pass.
// The receiver cannot stall; busy rises only while the two-entry queue is full.
module duration_stats_counter_table
  import dsct_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  request_t request,
  output logic     busy,
  output logic     done,
  output result_t  result
);

  queue_head_t head;
  logic        pop;

  dsct_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .head    (head),
    .pop     (pop)
  );

  dsct_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .done   (done),
    .result (result)
  );

endmodule

// File: rtl/core/dsct_checker.sv
// Port checker of the duration statistics table and its bind.
module dsct_checker
  import dsct_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input logic     done,
  input result_t  result
);

  // Each operation passes through a fetch and an update state in the back, so results never come back to back.
  a_done_spaced: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobes in two consecutive cycles");

  // No result follows reset directly.
  a_done_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  // The queue is empty after reset.
  a_busy_reset: assert property (@(posedge clk) rst |=> !busy)
    else $error("busy right after reset");

  // The queue cannot fill up without a word being accepted.
  a_busy_needs_word: assert property (@(posedge clk) disable iff (rst)
    (!busy && !start) |=> !busy)
    else $error("busy rose without an accepted word");

  // A result word carries known values.
  a_result_known: assert property (@(posedge clk) disable iff (rst)
    done |-> !$isunknown(result))
    else $error("result word with unknown bits");

endmodule

bind duration_stats_counter_table dsct_checker u_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .result  (result)
);
